@@ rtl/tst_pkg.sv @@
package tst_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int SECS_W     = 32;
    localparam int MOMENT_W   = 16;
    localparam int SLOT_W     = 8;
    localparam int DIV_STEP_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_DURATION = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_INTERVAL  = 8'd2;

    localparam logic [MOMENT_W-1:0] RST_CYCLE_DURATION = 16'd60;
    localparam logic [SLOT_W-1:0]   RST_SLOT_COUNT     = 8'd6;
    localparam logic [SLOT_W-1:0]   RST_SLOT_INTERVAL  = 8'd10;

    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_FULL = 6'd32;
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_HALF = 6'd16;

    typedef struct packed {
        logic                  start;
        logic [SECS_W-1:0]     dividend;
        logic [MOMENT_W-1:0]   divisor;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SECS_W-1:0]   quotient;
        logic [MOMENT_W-1:0] remainder;
    } t_div_rsp;

endpackage

@@ rtl/tst_if.sv @@
interface tst_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface tst_out_if;
    logic        valid;
    logic        ready;
    logic        is_synced;
    logic        sync_hit;
    logic        slot_changed;
    logic [7:0]  active_slot;
    logic [15:0] moment_second;

    modport source (output valid, output is_synced, output sync_hit, output slot_changed,
                    output active_slot, output moment_second, input ready);
    modport sink   (input valid, input is_synced, input sync_hit, input slot_changed,
                    input active_slot, input moment_second, output ready);
endinterface

interface tst_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tdm_slot_timer_top.sv @@
// channel | dir | handshake   | word
// i_in    | in  | valid/ready | unix_seconds[31:0]
// o_out   | out | valid/ready | is_synced, sync_hit, slot_changed, active_slot, moment_second
// i_cfg   | in  | valid/ready | index[7:0], data[15:0] (always ready)
//
// Synced tick: S_SYNC then S_DONE; input is accepted only in S_IDLE.
// Unsynced tick: S_MOD_DUR, S_CHK, S_MOD_INT, S_DONE (a zero divisor skips its divide); the
// shared one-bit-per-cycle divider runs 32 steps for cycle modulo, 16 for the slot divide.
// Reset is synchronous, active low; state and config registers return to defaults.
// A result waits in the output register; a new word is taken meanwhile and
// its result is held until the previous one is taken.
module tdm_slot_timer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tst_in_if.sink    i_in,
    tst_out_if.source o_out,
    tst_cfg_if.sink   i_cfg
);
    import tst_pkg::*;

    t_div_req div_req;
    t_div_rsp div_rsp;

    tst_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .o_req   (div_req),
        .i_rsp   (div_rsp)
    );

    tst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule

@@ rtl/tst_div.sv @@
module tst_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tst_pkg::t_div_req i_req,
    output tst_pkg::t_div_rsp o_rsp
);
    import tst_pkg::*;

    logic [SECS_W-1:0]     r_q;
    logic [MOMENT_W-1:0]   r_r;
    logic [MOMENT_W-1:0]   r_d;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [MOMENT_W:0] shifted;
    logic [MOMENT_W:0] diff;
    logic              ge;

    assign shifted = {r_r, r_q[SECS_W-1]};
    assign ge      = shifted >= {1'b0, r_d};
    assign diff    = shifted - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_r    <= '0;
                r_d    <= i_req.divisor;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[SECS_W-2:0], ge};
                r_r   <= ge ? diff[MOMENT_W-1:0] : shifted[MOMENT_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_r;

endmodule

@@ rtl/tst_core.sv @@
module tst_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tst_in_if.sink            i_in,
    tst_out_if.source         o_out,
    tst_cfg_if.sink           i_cfg,
    output tst_pkg::t_div_req o_req,
    input  tst_pkg::t_div_rsp i_rsp
);
    import tst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MOD_DUR, S_CHK, S_MOD_INT, S_SYNC, S_DONE
    } t_state;

    t_state r_state;

    logic [MOMENT_W-1:0] r_duration;
    logic [SLOT_W-1:0]   r_count;
    logic [SLOT_W-1:0]   r_interval;

    logic                r_synced;
    logic [MOMENT_W-1:0] r_moment;
    logic [MOMENT_W-1:0] r_start;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_hit;
    logic                r_step;

    t_div_req r_req;

    logic                r_out_valid;
    logic                r_o_synced;
    logic                r_o_hit;
    logic                r_o_step;
    logic [SLOT_W-1:0]   r_o_slot;
    logic [MOMENT_W-1:0] r_o_moment;

    logic                in_acc;
    logic                out_free;
    logic                div_go;
    logic [MOMENT_W-1:0] n_moment;
    logic [MOMENT_W:0]   elapsed;
    logic                do_step;
    logic [SLOT_W-1:0]   n_slot;
    logic                wrap;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign div_go   = ((r_state == S_IDLE) && in_acc && !r_synced && (r_duration != '0)) ||
                      ((r_state == S_CHK) && (r_interval != '0));

    assign n_moment = r_moment + 1'b1;
    assign elapsed  = {1'b0, n_moment} - {1'b0, r_start};
    assign do_step  = !elapsed[MOMENT_W] && (elapsed[MOMENT_W-1:0] >= {8'h0, r_interval});
    assign n_slot   = r_slot + 1'b1;
    assign wrap     = (r_count == '0) || (n_slot >= r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= RST_CYCLE_DURATION;
            r_count    <= RST_SLOT_COUNT;
            r_interval <= RST_SLOT_INTERVAL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_CYCLE_DURATION: r_duration <= i_cfg.data;
                CFG_SLOT_COUNT:     r_count    <= i_cfg.data[SLOT_W-1:0];
                CFG_SLOT_INTERVAL:  r_interval <= i_cfg.data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_synced    <= 1'b0;
            r_moment    <= '0;
            r_start     <= '0;
            r_slot      <= '0;
            r_hit       <= 1'b0;
            r_step      <= 1'b0;
            r_req       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= div_go;
            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_hit  <= 1'b0;
                        r_step <= 1'b0;
                        if (r_synced) begin
                            r_state <= S_SYNC;
                        end else if (r_duration == '0) begin
                            r_moment <= i_in.unix_seconds[MOMENT_W-1:0];
                            r_state  <= S_CHK;
                        end else begin
                            r_req.dividend <= i_in.unix_seconds;
                            r_req.divisor  <= r_duration;
                            r_req.steps    <= DIV_STEPS_FULL;
                            r_state        <= S_MOD_DUR;
                        end
                    end
                end
                S_MOD_DUR: begin
                    if (i_rsp.done) begin
                        r_moment <= i_rsp.remainder;
                        r_state  <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_interval == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_req.dividend <= {r_moment, 16'h0};
                        r_req.divisor  <= {8'h0, r_interval};
                        r_req.steps    <= DIV_STEPS_HALF;
                        r_state        <= S_MOD_INT;
                    end
                end
                S_MOD_INT: begin
                    if (i_rsp.done) begin
                        if (i_rsp.remainder == '0) begin
                            r_hit    <= 1'b1;
                            r_synced <= 1'b1;
                            r_start  <= r_moment;
                            r_slot   <= i_rsp.quotient[SLOT_W-1:0];
                        end
                        r_state <= S_DONE;
                    end
                end
                S_SYNC: begin
                    if (do_step) begin
                        r_step <= 1'b1;
                        if (wrap) begin
                            r_moment <= '0;
                            r_slot   <= '0;
                            r_start  <= '0;
                        end else begin
                            r_moment <= n_moment;
                            r_slot   <= n_slot;
                            r_start  <= n_moment;
                        end
                    end else begin
                        r_moment <= n_moment;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_synced  <= r_synced;
                        r_o_hit     <= r_hit;
                        r_o_step    <= r_step;
                        r_o_slot    <= r_slot;
                        r_o_moment  <= r_moment;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.is_synced     = r_o_synced;
    assign o_out.sync_hit      = r_o_hit;
    assign o_out.slot_changed  = r_o_step;
    assign o_out.active_slot   = r_o_slot;
    assign o_out.moment_second = r_o_moment;
    assign o_req               = r_req;

endmodule

@@ tb/sv/tb_tdm_slot_timer_top.sv @@
`timescale 1ns / 1ps

module tb_tdm_slot_timer_top;
    import tst_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int PRINT_LIMIT = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

    typedef struct packed {
        logic                is_synced;
        logic                sync_hit;
        logic                slot_changed;
        logic [SLOT_W-1:0]   active_slot;
        logic [MOMENT_W-1:0] moment_second;
    } t_tick_word;

    logic i_clk;
    logic i_rst_n;

    tst_in_if  in_if();
    tst_out_if out_if();
    tst_cfg_if cfg_if();

    tdm_slot_timer_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // schedule registers and state as the block should hold them
    logic [MOMENT_W-1:0] cfg_dur;
    logic [SLOT_W-1:0]   cfg_cnt;
    logic [SLOT_W-1:0]   cfg_ivl;
    logic                sch_synced;
    logic [MOMENT_W-1:0] sch_moment;
    logic [MOMENT_W-1:0] sch_start;
    logic [SLOT_W-1:0]   sch_slot;

    t_tick_word words_due[$];
    t_tick_word last_word;
    int         err_cnt   = 0;
    int         cycle_cnt = 0;
    int         rx_hold   = 0;
    bit         tx_idle   = 1'b0;
    bit         rx_idle   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_tick_word advance_schedule(input logic [SECS_W-1:0] secs);
        t_tick_word w;
        int         elapsed;
        w = '0;
        if (sch_synced) begin
            sch_moment = sch_moment + 16'd1;
            elapsed = int'(sch_moment) - int'(sch_start);
            if (elapsed >= int'(cfg_ivl)) begin
                w.slot_changed = 1'b1;
                sch_slot = sch_slot + 8'd1;
                if (cfg_cnt == '0 || sch_slot >= cfg_cnt) begin
                    sch_moment = '0;
                    sch_slot   = '0;
                end
                sch_start = sch_moment;
            end
        end else begin
            if (cfg_dur == '0) sch_moment = secs[MOMENT_W-1:0];
            else sch_moment = 16'(secs % cfg_dur);
            if (cfg_ivl != '0 && (sch_moment % cfg_ivl) == '0) begin
                w.sync_hit = 1'b1;
                sch_synced = 1'b1;
                sch_start  = sch_moment;
                sch_slot   = 8'(sch_moment / cfg_ivl);
            end
        end
        w.is_synced     = sch_synced;
        w.active_slot   = sch_slot;
        w.moment_second = sch_moment;
        return w;
    endfunction

    function automatic bit aligns_now(input logic [SECS_W-1:0] secs);
        logic [MOMENT_W-1:0] m;
        m = (cfg_dur == '0) ? secs[MOMENT_W-1:0] : 16'(secs % cfg_dur);
        return cfg_ivl != '0 && (m % cfg_ivl) == '0;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    function automatic logic [SLOT_W-1:0] pick_reg8();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3: return 8'($urandom_range(2, 12));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [MOMENT_W-1:0] pick_dur();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            3: return 16'($urandom_range(2, 100));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SECS_W-1:0] pick_secs();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        if (err_cnt < PRINT_LIMIT)
            $display("%0t mismatch %s: got %0h want %0h", $time, field, got, want);
        err_cnt++;
    endtask

    // in_if.valid stays high across back-to-back words
    task automatic send_tick(input logic [SECS_W-1:0] secs);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.unix_seconds <= secs;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        last_word = advance_schedule(secs);
        words_due.push_back(last_word);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_CYCLE_DURATION: cfg_dur = val;
            CFG_SLOT_COUNT:     cfg_cnt = val[SLOT_W-1:0];
            CFG_SLOT_INTERVAL:  cfg_ivl = val[SLOT_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits are don't-care for the 8-bit registers
    task automatic set_slots(input logic [SLOT_W-1:0] cnt, input logic [SLOT_W-1:0] ivl);
        write_reg(CFG_SLOT_COUNT, {8'($urandom), cnt});
        write_reg(CFG_SLOT_INTERVAL, {8'($urandom), ivl});
    endtask

    task automatic test_reset_defaults();
        send_tick(32'd61);
        send_tick(32'd127);
        send_tick(32'hFFFF_FFFF);
    endtask

    task automatic test_unsynced_modulo();
        logic [MOMENT_W-1:0] durs[4]   = '{16'd0, 16'd1, 16'hFFFF, 16'd7};
        logic [SECS_W-1:0]   probes[3] = '{32'h0, 32'hFFFF_FFFF, 32'h8001_0001};
        drain();
        set_slots(8'd6, 8'd0);
        foreach (durs[i]) begin
            write_reg(CFG_CYCLE_DURATION, durs[i]);
            foreach (probes[j]) send_tick(probes[j]);
            drain();
        end
    endtask

    // nonzero intervals only see seconds that miss alignment
    task automatic test_unsynced_random();
        logic [SECS_W-1:0]   secs;
        logic [MOMENT_W-1:0] d;
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            d = pick_dur();
            if (ph % 2 == 1 && d == 16'd1) d = 16'd0;
            write_reg(CFG_CYCLE_DURATION, d);
            set_slots(pick_reg8(), (ph % 2 == 1) ? 8'($urandom_range(2, 255)) : 8'd0);
            tx_idle = (ph != 2);
            rx_idle = (ph != 2);
            repeat (25) begin
                secs = pick_secs();
                while (aligns_now(secs)) secs = 32'($urandom);
                send_tick(secs);
            end
        end
    endtask

    // align at the top of the moment range, then ride the counter wrap
    task automatic test_sync_and_wrap();
        drain();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        write_reg(CFG_CYCLE_DURATION, 16'd0);
        set_slots(8'd6, 8'd1);
        send_tick(32'hFFFF_FFFF);
        drain();
        set_slots(8'd0, 8'd0);
        repeat (5) send_tick(32'($urandom));
        repeat (3) send_tick(32'($urandom));
    endtask

    task automatic test_synced_stepping();
        drain();
        set_slots(8'd3, 8'd2);
        repeat (8) send_tick(32'($urandom));
    endtask

    task automatic test_synced_random();
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            if (ph == 0) write_reg(CFG_UNUSED, 16'($urandom));
            write_reg(CFG_CYCLE_DURATION, pick_dur());
            set_slots(pick_reg8(), pick_reg8());
            tx_idle = (ph % 4 != 3) && ($urandom_range(0, 3) != 0);
            rx_idle = (ph % 4 != 3) && ($urandom_range(0, 3) != 0);
            repeat (50) send_tick(pick_secs());
        end
    endtask

    task automatic test_backpressure();
        drain();
        set_slots(8'd4, 8'd1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 400;
        repeat (30) send_tick(32'($urandom));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (20) send_tick(32'($urandom));
    endtask

    initial begin : rx_side
        int stall;
        stall = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                out_if.ready <= 1'b0;
            end else begin
                if (stall > 0) stall--;
                else if (rx_idle && $urandom_range(0, 99) < 20) stall = pick_gap();
                out_if.ready <= (stall == 0);
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        t_tick_word want;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (words_due.size() == 0) begin
                report("unexpected word", 32'(out_if.moment_second), 32'd0);
            end else begin
                want = words_due.pop_front();
                if (out_if.is_synced !== want.is_synced)
                    report("is_synced", 32'(out_if.is_synced), 32'(want.is_synced));
                if (out_if.sync_hit !== want.sync_hit)
                    report("sync_hit", 32'(out_if.sync_hit), 32'(want.sync_hit));
                if (out_if.slot_changed !== want.slot_changed)
                    report("slot_changed", 32'(out_if.slot_changed), 32'(want.slot_changed));
                if (out_if.active_slot !== want.active_slot)
                    report("active_slot", 32'(out_if.active_slot), 32'(want.active_slot));
                if (out_if.moment_second !== want.moment_second)
                    report("moment_second", 32'(out_if.moment_second),
                           32'(want.moment_second));
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.unix_seconds <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        cfg_dur    = RST_CYCLE_DURATION;
        cfg_cnt    = RST_SLOT_COUNT;
        cfg_ivl    = RST_SLOT_INTERVAL;
        sch_synced = 1'b0;
        sch_moment = '0;
        sch_start  = '0;
        sch_slot   = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_unsynced_modulo();
        test_unsynced_random();
        test_sync_and_wrap();
        test_synced_stepping();
        test_synced_random();
        test_backpressure();

        drain();
        repeat (60) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/tst_pkg.sv
rtl/tst_if.sv
rtl/tst_div.sv
rtl/tst_core.sv
rtl/tdm_slot_timer_top.sv
tb/sv/tb_tdm_slot_timer_top.sv
